// ===== rtl/tisl_pkg.sv =====
// ----------------------------------------------------------------------------
// tisl_pkg
// Shared types and constants for the sorted tile index table.
// ----------------------------------------------------------------------------
package tisl_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one table entry as stored in memory
  typedef struct packed {
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] offset;
    logic [31:0] length;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic       load;       // capture the request
    logic       clear;      // empty the table
    logic       rd_ins;     // read entry at pos - 1
    logic       shift;      // move read entry up to pos, step pos down
    logic       write_new;  // write request entry at pos, bump count, widen box
    logic       rd_lk;      // read entry at search midpoint
    logic       lk_lo;      // move low bound above midpoint
    logic       lk_hi;      // move high bound to midpoint
    logic       finish;     // load result word
    logic [1:0] res_status;
    logic       res_hit;    // take offset and length from read data
    logic       res_lookup; // report box test
  } tisl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       pos_zero;
    logic       above;
    logic       equal;
    logic       less;
    logic       search_empty;
  } tisl_sts_t;

endpackage

// ===== rtl/tisl_if.sv =====
// ----------------------------------------------------------------------------
// tisl_req_if / tisl_res_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tisl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] tile_x;
  logic [31:0] tile_y;
  logic [31:0] file_offset;
  logic [31:0] tile_length;

  modport source (output valid, req_type, tile_x, tile_y, file_offset, tile_length,
                  input ready);
  modport sink (input valid, req_type, tile_x, tile_y, file_offset, tile_length,
                output ready);
endinterface

interface tisl_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] hit_offset;
  logic [31:0] hit_length;
  logic        inside_box;
  logic [10:0] entries_held;

  modport source (output valid, status, hit_offset, hit_length, inside_box, entries_held,
                  input ready);
  modport sink (input valid, status, hit_offset, hit_length, inside_box, entries_held,
                output ready);
endinterface

// ===== rtl/tisl_ram.sv =====
// ----------------------------------------------------------------------------
// tisl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tisl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tisl_datapath.sv =====
// ----------------------------------------------------------------------------
// tisl_datapath
// Entry memory, count, bounding box, search bounds and result register.
// ----------------------------------------------------------------------------
module tisl_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tisl_pkg::tisl_cmd_t cmd,
  output tisl_pkg::tisl_sts_t sts,
  tisl_req_if.sink            in_ch,
  tisl_res_if.source          out_ch
);
  import tisl_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // request latch
  logic [1:0]  req_r;
  entry_t      ent_r;

  // table state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [CNT_W-1:0] pos_r, lo_r, hip1_r;
  logic [IDX_W-1:0] mid_r;
  logic [CNT_W:0]   mid_sum;

  // memory ports
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  entry_t           wr_data, rd_data;
  logic [ENTRY_W-1:0] rd_bits;

  // result register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [31:0] hit_off_r, hit_len_r;
  logic        inside_r;
  logic        in_box;

  tisl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );
  assign rd_data = entry_t'(rd_bits);

  // midpoint of lo .. hip1 - 1
  assign mid_sum = {1'b0, lo_r} + {1'b0, hip1_r} - (CNT_W+1)'(1);

  // memory port steering
  always_comb begin
    rd_en   = cmd.rd_ins | cmd.rd_lk;
    rd_addr = cmd.rd_ins ? IDX_W'(pos_r - CNT_W'(1)) : IDX_W'(mid_sum >> 1);
    wr_en   = cmd.shift | cmd.write_new;
    wr_addr = IDX_W'(pos_r);
    wr_data = cmd.shift ? rd_data : ent_r;
  end

  // key compare against read entry
  always_comb begin
    sts.req          = req_r;
    sts.full         = (count_r >= DEPTH_C);
    sts.pos_zero     = (pos_r == '0);
    sts.equal        = (rd_data.key_x == ent_r.key_x) && (rd_data.key_y == ent_r.key_y);
    sts.above        = (rd_data.key_x > ent_r.key_x) ||
                       ((rd_data.key_x == ent_r.key_x) && (rd_data.key_y > ent_r.key_y));
    sts.less         = (rd_data.key_x < ent_r.key_x) ||
                       ((rd_data.key_x == ent_r.key_x) && (rd_data.key_y < ent_r.key_y));
    sts.search_empty = (lo_r >= hip1_r);
  end

  assign in_box = (count_r != '0) &&
                  (ent_r.key_x >= min_x_r) && (ent_r.key_x <= max_x_r) &&
                  (ent_r.key_y >= min_y_r) && (ent_r.key_y <= max_y_r);

  // capture request and hold payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r        <= in_ch.req_type;
      ent_r.key_x  <= in_ch.tile_x;
      ent_r.key_y  <= in_ch.tile_y;
      ent_r.offset <= in_ch.file_offset;
      ent_r.length <= in_ch.tile_length;
    end
  end

  // advance insert position and search bounds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= count_r;
      lo_r   <= '0;
      hip1_r <= count_r;
    end else begin
      if (cmd.shift) begin
        pos_r <= pos_r - CNT_W'(1);
      end
      if (cmd.rd_lk) begin
        mid_r <= IDX_W'(mid_sum >> 1);
      end
      if (cmd.lk_lo) begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end
      if (cmd.lk_hi) begin
        hip1_r <= CNT_W'(mid_r);
      end
    end
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.write_new) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clear) begin
        min_x_r <= '0;
        max_x_r <= '0;
        min_y_r <= '0;
        max_y_r <= '0;
      end else if (cmd.write_new) begin
        // first entry sets the box, later ones widen it
        if (count_r == '0 || ent_r.key_x < min_x_r) min_x_r <= ent_r.key_x;
        if (count_r == '0 || ent_r.key_x > max_x_r) max_x_r <= ent_r.key_x;
        if (count_r == '0 || ent_r.key_y < min_y_r) min_y_r <= ent_r.key_y;
        if (count_r == '0 || ent_r.key_y > max_y_r) max_y_r <= ent_r.key_y;
      end
    end
  end

  // result word: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word: payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r  <= cmd.res_status;
      hit_off_r <= cmd.res_hit ? rd_data.offset : 32'd0;
      hit_len_r <= cmd.res_hit ? rd_data.length : 32'd0;
      inside_r  <= cmd.res_lookup & in_box;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.hit_offset   = hit_off_r;
  assign out_ch.hit_length   = hit_len_r;
  assign out_ch.inside_box   = inside_r;
  assign out_ch.entries_held = 11'(count_r);

endmodule

// ===== rtl/tisl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tisl_ctrl
// Request sequencer: insert shifting and binary search steps.
// ----------------------------------------------------------------------------
module tisl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_busy,
  output logic                in_ready,
  input  tisl_pkg::tisl_sts_t sts,
  output tisl_pkg::tisl_cmd_t cmd
);
  import tisl_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DECODE  = 6'b000010,
    S_INS_RD  = 6'b000100,
    S_INS_CMP = 6'b001000,
    S_LK_RD   = 6'b010000,
    S_LK_CMP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && !out_busy;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.req)
          REQ_CLEAR: begin
            cmd.clear  = 1'b1;
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_INS_RD;
            end
          end
          REQ_LOOKUP: begin
            state_nxt = S_LK_RD;
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_INS_RD: begin
        if (sts.pos_zero) begin
          cmd.write_new = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_ins = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.above) begin
          cmd.shift = 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          cmd.write_new = 1'b1;
          cmd.finish    = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_LK_RD: begin
        if (sts.search_empty) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_MISS;
          cmd.res_lookup = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.rd_lk = 1'b1;
          state_nxt = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (sts.equal) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_DONE;
          cmd.res_hit    = 1'b1;
          cmd.res_lookup = 1'b1;
          state_nxt      = S_IDLE;
        end else if (sts.less) begin
          cmd.lk_lo = 1'b1;
          state_nxt = S_LK_RD;
        end else begin
          cmd.lk_hi = 1'b1;
          state_nxt = S_LK_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/tile_index_sorted_lookup.sv =====
// ----------------------------------------------------------------------------
// tile_index_sorted_lookup
// Sorted tile index table with bounding box and binary search lookup.
// ----------------------------------------------------------------------------
// Requests are taken one at a time; a new request is accepted in the cycle
// after the previous result word has been taken. Clear, unused request types
// and refused inserts finish straight from decode. A lookup is a binary search
// with at most 11 memory probes for 1024 entries; a miss needs one more step to
// see the empty range. Each probe is a read step and a compare step on the single
// registered read port of the entry memory. An insert shifts entries up one at a
// time, each with a read and a write, to open its slot before it writes the new
// entry, so sorted loading in ascending key order needs no shifts.
// ----------------------------------------------------------------------------
module tile_index_sorted_lookup (
  input logic        clk,
  input logic        rst_n,
  tisl_req_if.sink   in_ch,
  tisl_res_if.source out_ch
);
  import tisl_pkg::*;

  tisl_cmd_t cmd;
  tisl_sts_t sts;

  tisl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_busy (out_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tisl_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted tile index table. A local model of the
// table and its bounding box predicts each result word. It runs a directed
// table of requests, fills the table up to the full refusal, and then sends
// random insert, lookup and clear traffic. Both channels idle and stall at
// random.
// ----------------------------------------------------------------------------
module tb_top;
  import tisl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_ITEMS = 450;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  req_type;
    logic [31:0] tile_x;
    logic [31:0] tile_y;
    logic [31:0] file_offset;
    logic [31:0] tile_length;
  } tile_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] hit_offset;
    logic [31:0] hit_length;
    logic        inside_box;
    logic [10:0] entries_held;
  } tile_res_t;

  // directed row: request plus an optional typed-in result word
  typedef struct {
    tile_req_t rq;
    bit        typed;
    tile_res_t rs;
  } directed_row_t;

  logic clk;
  logic rst_n;

  tisl_req_if in_ch ();
  tisl_res_if out_ch ();

  tile_index_sorted_lookup dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the table
  logic [31:0] tbl_x   [TABLE_DEPTH];
  logic [31:0] tbl_y   [TABLE_DEPTH];
  logic [31:0] tbl_off [TABLE_DEPTH];
  logic [31:0] tbl_len [TABLE_DEPTH];
  int unsigned tbl_count;
  logic [31:0] bx_min_x, bx_max_x, bx_min_y, bx_max_y;

  tile_res_t   expected_words[$];
  int unsigned mismatch_count;
  int unsigned words_seen;
  int unsigned cycle_count;
  bit          fast_mode;
  logic [31:0] key_pool_x[$];
  logic [31:0] key_pool_y[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** tile_index_sorted_lookup: FAILED **");
      $finish;
    end
  end

  // advance the local table by one request and return its result word
  function automatic tile_res_t predict_table_op(tile_req_t rq);
    tile_res_t   rs;
    int          pos, lo, hi, mid;
    bit          hit;
    rs = '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd0};
    case (rq.req_type)
      REQ_CLEAR: begin
        tbl_count = 0;
        bx_min_x = 0; bx_max_x = 0; bx_min_y = 0; bx_max_y = 0;
      end
      REQ_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          pos = tbl_count;
          while (pos > 0 && (tbl_x[pos-1] > rq.tile_x ||
                 (tbl_x[pos-1] == rq.tile_x && tbl_y[pos-1] > rq.tile_y))) begin
            tbl_x[pos] = tbl_x[pos-1];
            tbl_y[pos] = tbl_y[pos-1];
            tbl_off[pos] = tbl_off[pos-1];
            tbl_len[pos] = tbl_len[pos-1];
            pos--;
          end
          tbl_x[pos] = rq.tile_x;
          tbl_y[pos] = rq.tile_y;
          tbl_off[pos] = rq.file_offset;
          tbl_len[pos] = rq.tile_length;
          if (tbl_count == 0) begin
            bx_min_x = rq.tile_x; bx_max_x = rq.tile_x;
            bx_min_y = rq.tile_y; bx_max_y = rq.tile_y;
          end else begin
            if (rq.tile_x < bx_min_x) bx_min_x = rq.tile_x;
            if (rq.tile_x > bx_max_x) bx_max_x = rq.tile_x;
            if (rq.tile_y < bx_min_y) bx_min_y = rq.tile_y;
            if (rq.tile_y > bx_max_y) bx_max_y = rq.tile_y;
          end
          tbl_count++;
        end
      end
      REQ_LOOKUP: begin
        lo = 0;
        hi = int'(tbl_count) - 1;
        hit = 1'b0;
        while (lo <= hi && !hit) begin
          mid = (lo + hi) / 2;
          if (tbl_x[mid] == rq.tile_x && tbl_y[mid] == rq.tile_y) begin
            hit = 1'b1;
            rs.hit_offset = tbl_off[mid];
            rs.hit_length = tbl_len[mid];
          end else if (tbl_x[mid] < rq.tile_x ||
                       (tbl_x[mid] == rq.tile_x && tbl_y[mid] < rq.tile_y)) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (!hit) rs.status = ST_MISS;
        rs.inside_box = (tbl_count > 0) && rq.tile_x >= bx_min_x && rq.tile_x <= bx_max_x &&
                        rq.tile_y >= bx_min_y && rq.tile_y <= bx_max_y;
      end
      default: ;
    endcase
    rs.entries_held = tbl_count[10:0];
    return rs;
  endfunction

  // pick a gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (fast_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // offer one word and hold it until taken; typed result overrides the model
  task automatic send_word(tile_req_t rq, bit typed, tile_res_t typed_rs);
    tile_res_t rs;
    int        gap;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= rq.req_type;
    in_ch.tile_x      <= rq.tile_x;
    in_ch.tile_y      <= rq.tile_y;
    in_ch.file_offset <= rq.file_offset;
    in_ch.tile_length <= rq.tile_length;
    do @(posedge clk); while (!in_ch.ready);
    rs = predict_table_op(rq);
    expected_words.push_back(typed ? typed_rs : rs);
    if (rq.req_type == REQ_INSERT) begin
      key_pool_x.push_back(rq.tile_x);
      key_pool_y.push_back(rq.tile_y);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // random request: mostly inserts and lookups on a small key space
  function automatic tile_req_t random_req();
    tile_req_t rq;
    int        r, k;
    r = $urandom_range(0, 99);
    rq.req_type = (r < 4) ? REQ_CLEAR : (r < 48) ? REQ_INSERT : (r < 94) ? REQ_LOOKUP
                                                                         : REQ_UNUSED;
    rq.tile_x = $urandom_range(0, 9);
    rq.tile_y = $urandom_range(0, 9);
    r = $urandom_range(0, 99);
    if (r < 10) begin
      rq.tile_x = $urandom();
      rq.tile_y = $urandom();
    end else if (r < 15) begin
      rq.tile_x = 32'hFFFF_FFFF - rq.tile_x;
      rq.tile_y = 32'hFFFF_FFFF - rq.tile_y;
    end else if (rq.req_type == REQ_LOOKUP && r < 70 && key_pool_x.size() != 0) begin
      k = $urandom_range(0, key_pool_x.size() - 1);
      rq.tile_x = key_pool_x[k];
      rq.tile_y = key_pool_y[k];
    end
    rq.file_offset = $urandom();
    rq.tile_length = $urandom();
    return rq;
  endfunction

  // result side: random ready, one long hold-off partway through
  int unsigned hold_left;
  bit          held_once;
  always @(posedge clk) begin
    tile_res_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.hit_offset, out_ch.hit_length,
                out_ch.inside_box, out_ch.entries_held};
        words_seen <= words_seen + 1;
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status || got.hit_offset !== want.hit_offset ||
              got.hit_length !== want.hit_length || got.inside_box !== want.inside_box ||
              got.entries_held !== want.entries_held) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (!held_once && words_seen == 1300) begin
        held_once <= 1'b1;
        hold_left <= 400;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (fast_mode) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 2) hold_left <= $urandom_range(20, 60);
      end
    end
  end

  directed_row_t rows[$];

  // stimulus
  initial begin
    tile_req_t rq;
    tile_res_t none;
    none = '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd0};
    cycle_count = 0;
    mismatch_count = 0;
    words_seen = 0;
    hold_left = 0;
    held_once = 1'b0;
    fast_mode = 1'b0;
    tbl_count = 0;
    bx_min_x = 0; bx_max_x = 0; bx_min_y = 0; bx_max_y = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CLEAR;
    in_ch.tile_x = '0;
    in_ch.tile_y = '0;
    in_ch.file_offset = '0;
    in_ch.tile_length = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    rows.push_back('{'{REQ_LOOKUP, 32'd5, 32'd5, 32'd0, 32'd0}, 1,
                     '{ST_MISS, 32'd0, 32'd0, 1'b0, 11'd0}});
    rows.push_back('{'{REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF}, 1, '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd0}});
    rows.push_back('{'{REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF}, 1, '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd1}});
    rows.push_back('{'{REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0}, 1,
                     '{ST_DONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 11'd1}});
    rows.push_back('{'{REQ_INSERT, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
                     '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd2}});
    rows.push_back('{'{REQ_INSERT, 32'd7, 32'd3, 32'h1111_0000, 32'h0000_0100}, 0, none});
    rows.push_back('{'{REQ_INSERT, 32'd7, 32'd3, 32'h2222_0000, 32'h0000_0200}, 0, none});
    rows.push_back('{'{REQ_INSERT, 32'd7, 32'd2, 32'h3333_0000, 32'h0000_0300}, 0, none});
    rows.push_back('{'{REQ_INSERT, 32'd3, 32'd9, 32'h5555_AAAA, 32'hAAAA_5555}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd7, 32'd3, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd7, 32'd2, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd3, 32'd9, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd4, 32'd4, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
                     '{ST_DONE, 32'd0, 32'd0, 1'b0, 11'd0}});
    rows.push_back('{'{REQ_INSERT, 32'd100, 32'd200, 32'hDEAD_0001, 32'h0000_0040}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd99, 32'd200, 32'd0, 32'd0}, 1,
                     '{ST_MISS, 32'd0, 32'd0, 1'b0, 11'd1}});
    rows.push_back('{'{REQ_LOOKUP, 32'd100, 32'd200, 32'd0, 32'd0}, 1,
                     '{ST_DONE, 32'hDEAD_0001, 32'h0000_0040, 1'b1, 11'd1}});
    rows.push_back('{'{REQ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0}, 0, none});
    rows.push_back('{'{REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0}, 1,
                     '{ST_MISS, 32'd0, 32'd0, 1'b0, 11'd0}});
    foreach (rows[i]) send_word(rows[i].rq, rows[i].typed, rows[i].rs);

    // pause until every result is back
    drain_results();

    // fill the table in ascending key order, then get refused
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      rq = '{REQ_INSERT, 32'(i * 3), $urandom(), $urandom(), $urandom()};
      send_word(rq, 0, none);
    end
    send_word('{REQ_INSERT, 32'd5, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
              '{ST_FULL, 32'd0, 32'd0, 1'b0, 11'd1024});
    for (int i = 0; i < 12; i++) begin
      rq = '{REQ_LOOKUP, 32'($urandom_range(0, 3 * TABLE_DEPTH)), 32'd0, 32'd0, 32'd0};
      if (i % 2 == 0) begin
        rq.tile_x = 32'(3 * $urandom_range(0, TABLE_DEPTH - 1));
        for (int j = 0; j < TABLE_DEPTH; j++)
          if (tbl_x[j] == rq.tile_x) rq.tile_y = tbl_y[j];
      end
      send_word(rq, 0, none);
    end
    send_word('{REQ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0}, 0, none);
    key_pool_x.delete();
    key_pool_y.delete();

    // random traffic, with stretches of no idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) fast_mode = ($urandom_range(0, 3) == 0);
      if (tbl_count > 120) rq = '{REQ_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0};
      else rq = random_req();
      if (rq.req_type == REQ_CLEAR) begin
        key_pool_x.delete();
        key_pool_y.delete();
      end
      send_word(rq, 0, none);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("** tile_index_sorted_lookup: PASSED **");
    end else begin
      $display("** tile_index_sorted_lookup: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tisl_pkg.sv
rtl/tisl_if.sv
rtl/tisl_ram.sv
rtl/tisl_datapath.sv
rtl/tisl_ctrl.sv
rtl/tile_index_sorted_lookup.sv
tb/tb_top.sv
